// File: src/echo_range_median_filter_top_defines.svh
// Assertion macros shared by the echo range median filter RTL.
`ifndef ECHO_RANGE_MEDIAN_FILTER_TOP_DEFINES_SVH
`define ECHO_RANGE_MEDIAN_FILTER_TOP_DEFINES_SVH

// Antecedent and consequent checked in the same cycle.
`define ERM_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("erm assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ERM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("erm assertion failed");

`endif

// File: src/erm_pkg.sv
// Shared constants, types and a helper function of the echo range median filter.
package erm_pkg;

  localparam int TIMER_W    = 16;
  localparam int DUR_W      = 18;
  localparam int DIST_W     = 19;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 6;
  localparam int BCD_W      = DIGIT_W * NUM_DIGITS;
  localparam int PROD_W     = 27;
  localparam int REM_W      = 8;
  localparam int CNT_W      = 5;

  // Distance scale 3432/2000 reduced to 429/250.
  localparam int DIST_NUM_W   = 9;
  localparam int DIST_NUM_IDX = $clog2(DIST_NUM_W);
  localparam logic [DIST_NUM_W-1:0] DIST_NUM = 9'd429;
  localparam logic [REM_W-1:0]      DIST_DEN = 8'd250;

  typedef struct packed {
    logic busy;
    logic done;
  } erm_stat_t;

  typedef struct packed {
    logic [DUR_W-1:0]  median;
    logic [DIST_W-1:0] range_mm;
    logic [BCD_W-1:0]  bcd;
  } erm_res_t;

  function automatic logic [DUR_W-1:0] median3(input logic [DUR_W-1:0] a,
                                               input logic [DUR_W-1:0] b,
                                               input logic [DUR_W-1:0] c);
    logic [DUR_W-1:0] lo_ab;
    logic [DUR_W-1:0] hi_ab;
    logic [DUR_W-1:0] lo_hc;
    lo_ab = (a < b) ? a : b;
    hi_ab = (a < b) ? b : a;
    lo_hc = (hi_ab < c) ? hi_ab : c;
    return (lo_ab > lo_hc) ? lo_ab : lo_hc;
  endfunction

endpackage

// File: src/erm_conv.sv
// Bit-serial distance conversion: multiply, divide and binary-to-BCD.
module erm_conv (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [erm_pkg::DUR_W-1:0]      median,
  input  logic                           ack,
  output erm_pkg::erm_stat_t             stat,
  output erm_pkg::erm_res_t              res
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_BCD  = 5'b01000,
    ST_HOLD = 5'b10000
  } conv_state_t;

  conv_state_t                     state_r, state_nxt;
  logic [erm_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [erm_pkg::PROD_W-1:0]      acc_r, acc_nxt;
  logic [erm_pkg::REM_W-1:0]       rem_r, rem_nxt;
  logic [erm_pkg::DUR_W-1:0]       med_r, med_nxt;
  logic [erm_pkg::DIST_W-1:0]      dist_r, dist_nxt;
  logic [erm_pkg::BCD_W-1:0]       bcd_r, bcd_nxt;

  logic [erm_pkg::REM_W:0]         trial;
  logic [erm_pkg::REM_W:0]         trial_sub;
  logic                            trial_ge;
  logic [erm_pkg::BCD_W-1:0]       bcd_adj;
  logic [erm_pkg::PROD_W-1:0]      addend;

  // One restoring division step against the constant divisor.
  assign trial     = {rem_r, acc_r[erm_pkg::PROD_W-1]};
  assign trial_ge  = trial >= {1'b0, erm_pkg::DIST_DEN};
  assign trial_sub = trial - {1'b0, erm_pkg::DIST_DEN};

  assign addend = erm_pkg::DIST_NUM[cnt_r[erm_pkg::DIST_NUM_IDX-1:0]] ?
                  {{(erm_pkg::PROD_W-erm_pkg::DUR_W){1'b0}}, med_r} :
                  '0;

  always_comb begin
    for (int i = 0; i < erm_pkg::NUM_DIGITS; i++) begin
      if (bcd_r[i*erm_pkg::DIGIT_W +: erm_pkg::DIGIT_W] >= 4'd5) begin
        bcd_adj[i*erm_pkg::DIGIT_W +: erm_pkg::DIGIT_W] =
          bcd_r[i*erm_pkg::DIGIT_W +: erm_pkg::DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[i*erm_pkg::DIGIT_W +: erm_pkg::DIGIT_W] =
          bcd_r[i*erm_pkg::DIGIT_W +: erm_pkg::DIGIT_W];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    med_nxt   = med_r;
    dist_nxt  = dist_r;
    bcd_nxt   = bcd_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          med_nxt   = median;
          acc_nxt   = '0;
          cnt_nxt   = erm_pkg::CNT_W'(erm_pkg::DIST_NUM_W - 1);
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // Scan the multiplier constant from its top bit down.
        acc_nxt = {acc_r[erm_pkg::PROD_W-2:0], 1'b0} + addend;
        if (cnt_r == '0) begin
          cnt_nxt   = erm_pkg::CNT_W'(erm_pkg::PROD_W - 1);
          rem_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_DIV: begin
        rem_nxt = trial_ge ? trial_sub[erm_pkg::REM_W-1:0] : trial[erm_pkg::REM_W-1:0];
        acc_nxt = {acc_r[erm_pkg::PROD_W-2:0], trial_ge};
        if (cnt_r == '0) begin
          dist_nxt  = acc_nxt[erm_pkg::DIST_W-1:0];
          acc_nxt   = {{(erm_pkg::PROD_W-erm_pkg::DIST_W){1'b0}},
                       acc_nxt[erm_pkg::DIST_W-1:0]};
          bcd_nxt   = '0;
          cnt_nxt   = erm_pkg::CNT_W'(erm_pkg::DIST_W - 1);
          state_nxt = ST_BCD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_BCD: begin
        // Double dabble: adjust every digit, then shift in the next bit.
        bcd_nxt = {bcd_adj[erm_pkg::BCD_W-2:0], acc_r[erm_pkg::DIST_W-1]};
        acc_nxt = {acc_r[erm_pkg::PROD_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          state_nxt = ST_HOLD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_HOLD: begin
        if (ack) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    med_r  <= med_nxt;
    dist_r <= dist_nxt;
    bcd_r  <= bcd_nxt;
  end

  assign stat.busy    = (state_r != ST_IDLE);
  assign stat.done    = (state_r == ST_HOLD);
  assign res.median   = med_r;
  assign res.range_mm = dist_r;
  assign res.bcd      = bcd_r;

endmodule

// File: src/echo_range_median_filter_top.sv
// Top level of the echo range median filter.
//
// The input channel carries echo edge words: in_kind is 0 for a rising edge
// and 1 for a falling edge, and in_timer_value is the free-running timer count
// stamped at that edge. A rising edge opens a measurement when none is open.
// A falling edge closes it; when its count is above the start count, the
// duration (end - start) * 3 enters a three-deep history and one result word
// leaves on the output channel: the history median, the distance in
// millimeters and its six decimal digits. Other edges produce no word.
// Edges that produce no word do not hold up the next edge. A valid falling
// edge sets s1, which shifts the history and sets s2, which starts the serial
// converter; the result word goes out once the converter is done, and the next
// edge is taken once the converter is idle again. The converter runs 9
// multiply steps, 27 divide steps and 19 BCD steps, one bit per cycle each.
// Reset clears the open measurement, the history and all handshake state.
// If the receiver stalls, the finished word waits in the output register
// while the converter is free; a second finished word waits inside the
// converter, which holds in_ready low until the output register drains.
`include "echo_range_median_filter_top_defines.svh"

module echo_range_median_filter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [erm_pkg::TIMER_W-1:0]   in_timer_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [erm_pkg::DUR_W-1:0]     out_median_duration,
  output logic [erm_pkg::DIST_W-1:0]    out_range_mm,
  output logic [erm_pkg::DIGIT_W-1:0]   out_digit_hundred_thousands,
  output logic [erm_pkg::DIGIT_W-1:0]   out_digit_ten_thousands,
  output logic [erm_pkg::DIGIT_W-1:0]   out_digit_thousands,
  output logic [erm_pkg::DIGIT_W-1:0]   out_digit_hundreds,
  output logic [erm_pkg::DIGIT_W-1:0]   out_digit_tens,
  output logic [erm_pkg::DIGIT_W-1:0]   out_digit_ones
);

  logic                          pending_r, pending_nxt;
  logic [erm_pkg::TIMER_W-1:0]   start_r, start_nxt;
  logic                          s1_r, s1_nxt;
  logic                          s2_r, s2_nxt;
  logic [erm_pkg::TIMER_W-1:0]   diff_r, diff_nxt;
  logic [erm_pkg::DUR_W-1:0]     newest_r, newest_nxt;
  logic [erm_pkg::DUR_W-1:0]     middle_r, middle_nxt;
  logic [erm_pkg::DUR_W-1:0]     oldest_r, oldest_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [erm_pkg::DUR_W-1:0]     out_med_r;
  logic [erm_pkg::DIST_W-1:0]    out_dist_r;
  logic [erm_pkg::BCD_W-1:0]     out_bcd_r;

  logic                          in_fire;
  logic [erm_pkg::TIMER_W:0]     sub;
  logic                          edge_good;
  logic [erm_pkg::DUR_W-1:0]     dur;
  logic [erm_pkg::DUR_W-1:0]     median;
  logic                          load;
  erm_pkg::erm_stat_t            stat;
  erm_pkg::erm_res_t             res;

  assign in_ready = !s1_r && !s2_r && !stat.busy;
  assign in_fire  = in_valid && in_ready;

  // The borrow bit of the subtraction doubles as the ordering compare.
  assign sub       = {1'b0, in_timer_value} - {1'b0, start_r};
  assign edge_good = pending_r && !sub[erm_pkg::TIMER_W] && (sub != '0);

  // Duration times three as one add of the value and its double.
  assign dur = {2'b00, diff_r} + {1'b0, diff_r, 1'b0};

  assign median = erm_pkg::median3(newest_r, middle_r, oldest_r);

  // The converter hands its word over when the output register is free.
  assign load = stat.done && (!out_valid_r || out_ready);

  always_comb begin
    pending_nxt = pending_r;
    start_nxt   = start_r;
    s1_nxt      = 1'b0;
    s2_nxt      = 1'b0;
    diff_nxt    = diff_r;
    newest_nxt  = newest_r;
    middle_nxt  = middle_r;
    oldest_nxt  = oldest_r;
    if (in_fire) begin
      if (!in_kind) begin
        if (!pending_r) begin
          start_nxt   = in_timer_value;
          pending_nxt = 1'b1;
        end
      end else begin
        pending_nxt = 1'b0;
        start_nxt   = '0;
        if (edge_good) begin
          s1_nxt   = 1'b1;
          diff_nxt = sub[erm_pkg::TIMER_W-1:0];
        end
      end
    end
    if (s1_r) begin
      oldest_nxt = middle_r;
      middle_nxt = newest_r;
      newest_nxt = dur;
      s2_nxt     = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  erm_conv u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (s2_r),
    .median (median),
    .ack    (load),
    .stat   (stat),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      start_r     <= '0;
      s1_r        <= 1'b0;
      s2_r        <= 1'b0;
      newest_r    <= '0;
      middle_r    <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      start_r     <= start_nxt;
      s1_r        <= s1_nxt;
      s2_r        <= s2_nxt;
      newest_r    <= newest_nxt;
      middle_r    <= middle_nxt;
      oldest_r    <= oldest_nxt;
      out_valid_r <= out_valid_nxt;
    end
    diff_r <= diff_nxt;
    if (load) begin
      out_med_r  <= res.median;
      out_dist_r <= res.range_mm;
      out_bcd_r  <= res.bcd;
    end
  end

  assign out_valid                   = out_valid_r;
  assign out_median_duration         = out_med_r;
  assign out_range_mm                = out_dist_r;
  assign out_digit_hundred_thousands = out_bcd_r[23:20];
  assign out_digit_ten_thousands     = out_bcd_r[19:16];
  assign out_digit_thousands         = out_bcd_r[15:12];
  assign out_digit_hundreds          = out_bcd_r[11:8];
  assign out_digit_tens              = out_bcd_r[7:4];
  assign out_digit_ones              = out_bcd_r[3:0];

  // A new output word only ever comes from a finished conversion.
  `ERM_ASSERT_SAME(a_out_from_conv, $rose(out_valid_r), $past(stat.done))
  // The converter is started only when it is idle.
  `ERM_ASSERT_SAME(a_start_idle, s2_r, !stat.busy)
  // A valid falling edge sets s1_r in the next cycle and drops in_ready.
  `ERM_ASSERT_NEXT(a_hist_follow, in_fire && in_kind && edge_good, s1_r && !in_ready)
  // Every decimal digit of a delivered word is in range.
  `ERM_ASSERT_SAME(a_digits_ok, out_valid_r,
    (out_bcd_r[3:0] <= 4'd9) && (out_bcd_r[7:4] <= 4'd9) && (out_bcd_r[11:8] <= 4'd9) &&
    (out_bcd_r[15:12] <= 4'd9) && (out_bcd_r[19:16] <= 4'd9) && (out_bcd_r[23:20] <= 4'd9))

endmodule
